// ===== hdl/ppnm_pkg.sv =====
// ----------------------------------------------------------------------------
// ppnm_pkg
// name tables, character codes and scan phase type for the path name matcher
// ----------------------------------------------------------------------------
package ppnm_pkg;

  localparam int unsigned NUM_ROOT  = 13;
  localparam int unsigned NUM_ANY   = 3;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned STR_W     = 128;

  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  typedef enum logic [1:0] {
    PH_SEEK_COLON  = 2'd0,
    PH_AFTER_COLON = 2'd1,
    PH_REST        = 2'd2
  } phase_e;

  // names are right-justified, first character in the highest used byte
  localparam logic [STR_W-1:0] ROOT_STR [NUM_ROOT] = '{
    STR_W'("BOOT.ELF"),
    STR_W'("BOOT.NEW"),
    STR_W'("BOOT.BAK"),
    STR_W'("BADISK.ELF"),
    STR_W'("BAEXEC-SYSTEM"),
    STR_W'("BREXEC-SYSTEM"),
    STR_W'("BIEXEC-SYSTEM"),
    STR_W'("SYS-CONF"),
    STR_W'("BWNETCNF"),
    STR_W'("BADATA-SYSTEM"),
    STR_W'("BOOT"),
    STR_W'("APPS"),
    STR_W'(40'h41_54_4C_41_53)
  };

  localparam logic [POS_W-1:0] ROOT_LEN [NUM_ROOT] = '{
    4'd8, 4'd8, 4'd8, 4'd10, 4'd13, 4'd13, 4'd13, 4'd8, 4'd8, 4'd13, 4'd4, 4'd4, 4'd5
  };

  localparam logic [STR_W-1:0] ANY_STR [NUM_ANY] = '{
    STR_W'("SYS-CONF"),
    STR_W'("BADATA-SYSTEM"),
    STR_W'("BWNETCNF")
  };

  localparam logic [POS_W-1:0] ANY_LEN [NUM_ANY] = '{4'd8, 4'd13, 4'd8};

  // true when the name has character ch at position pos
  function automatic logic name_hit(logic [STR_W-1:0] str, logic [POS_W-1:0] len,
                                    logic [POS_W-1:0] pos, logic [7:0] ch);
    logic [POS_W-1:0] idx;
    logic [7:0]       name_ch;
    idx     = len - pos - POS_W'(1);
    name_ch = str[{idx, 3'b000} +: 8];
    return (pos < len) && (name_ch == ch);
  endfunction

  function automatic logic [7:0] fold_upper(logic [7:0] ch);
    if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      return ch - CASE_DELTA;
    end
    return ch;
  endfunction

endpackage

// ===== hdl/path_protected_name_matcher.sv =====
// ----------------------------------------------------------------------------
// path_protected_name_matcher
// streams a device path one character per transfer and flags protected paths
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------
//  in      | sink      | in_valid_i / in_stall_o  | char_code_i, last_char_i
//  out     | source    | out_valid_o / out_stall_i| is_protected_o, is_device_root_o
//
// one character is taken per cycle while not stalled; the per-character compare
// against the name tables plus the state update fit between the input and the
// scan state registers, so the sustained rate is one transfer per clock while
// not stalled; the result of a path appears in the output register in the cycle
// after its last character; reset clears scan state and the output valid at once
// a stalled result holds in the output register; characters that are not
// the last of a path keep flowing while the result waits
// ----------------------------------------------------------------------------
module path_protected_name_matcher (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_protected_o,
  output logic       is_device_root_o
);
  import ppnm_pkg::*;

  // scan state
  phase_e              phase_q, phase_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [NUM_ROOT-1:0] root_alive_q, root_alive_d;
  logic [NUM_ANY-1:0]  any_alive_q, any_alive_d;
  logic                first_comp_q, first_comp_d;
  logic                rest_seen_q, rest_seen_d;
  logic                match_q, match_d;

  // output register
  logic out_valid_q, out_valid_d;
  logic prot_q, prot_d;
  logic root_q, root_d;

  logic       in_xfer;
  logic [7:0] ch_fold;
  logic       feed;

  // state after this character, before the end-of-path clear
  phase_e              phase_n;
  logic [POS_W-1:0]    pos_n;
  logic [NUM_ROOT-1:0] root_alive_n;
  logic [NUM_ANY-1:0]  any_alive_n;
  logic                first_comp_n;
  logic                rest_seen_n;
  logic                match_n;
  logic                comp_hit_n;

  // a last character may only enter while the output register can take it
  assign in_stall_o = out_valid_q && out_stall_i && last_char_i;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign ch_fold    = fold_upper(char_code_i);

  // the byte right after the colon is skipped when it is a slash
  assign feed = (phase_q == PH_REST) ||
                ((phase_q == PH_AFTER_COLON) && (char_code_i != CH_SLASH));

  // next scan state
  always_comb begin
    phase_n      = phase_q;
    pos_n        = pos_q;
    root_alive_n = root_alive_q;
    any_alive_n  = any_alive_q;
    first_comp_n = first_comp_q;
    rest_seen_n  = rest_seen_q;
    match_n      = match_q;

    case (phase_q)
      PH_SEEK_COLON: begin
        if (char_code_i == CH_COLON) begin
          phase_n = PH_AFTER_COLON;
        end
      end
      PH_AFTER_COLON: phase_n = PH_REST;
      PH_REST:        phase_n = PH_REST;
      default:        phase_n = PH_SEEK_COLON;
    endcase

    if (feed) begin
      rest_seen_n = 1'b1;
      if (char_code_i == CH_SLASH) begin
        // component boundary: fold the finished component into the match flag
        for (int i = 0; i < NUM_ROOT; i++) begin
          if (first_comp_q && root_alive_q[i] && pos_q == ROOT_LEN[i]) begin
            match_n = 1'b1;
          end
        end
        for (int i = 0; i < NUM_ANY; i++) begin
          if (any_alive_q[i] && pos_q == ANY_LEN[i]) begin
            match_n = 1'b1;
          end
        end
        pos_n        = '0;
        root_alive_n = '1;
        any_alive_n  = '1;
        first_comp_n = 1'b0;
      end else begin
        // knock out every name that differs at this position
        for (int i = 0; i < NUM_ROOT; i++) begin
          if (!name_hit(ROOT_STR[i], ROOT_LEN[i], pos_q, ch_fold)) begin
            root_alive_n[i] = 1'b0;
          end
        end
        for (int i = 0; i < NUM_ANY; i++) begin
          if (!name_hit(ANY_STR[i], ANY_LEN[i], pos_q, ch_fold)) begin
            any_alive_n[i] = 1'b0;
          end
        end
        pos_n = (pos_q < POS_MAX) ? pos_q + POS_W'(1) : POS_MAX;
      end
    end
  end

  // open component at the end of the path
  always_comb begin
    comp_hit_n = 1'b0;
    for (int i = 0; i < NUM_ROOT; i++) begin
      if (first_comp_n && root_alive_n[i] && pos_n == ROOT_LEN[i]) begin
        comp_hit_n = 1'b1;
      end
    end
    for (int i = 0; i < NUM_ANY; i++) begin
      if (any_alive_n[i] && pos_n == ANY_LEN[i]) begin
        comp_hit_n = 1'b1;
      end
    end
  end

  // register updates; the path state returns to reset after its last character
  always_comb begin
    phase_d      = phase_q;
    pos_d        = pos_q;
    root_alive_d = root_alive_q;
    any_alive_d  = any_alive_q;
    first_comp_d = first_comp_q;
    rest_seen_d  = rest_seen_q;
    match_d      = match_q;
    if (in_xfer) begin
      if (last_char_i) begin
        phase_d      = PH_SEEK_COLON;
        pos_d        = '0;
        root_alive_d = '1;
        any_alive_d  = '1;
        first_comp_d = 1'b1;
        rest_seen_d  = 1'b0;
        match_d      = 1'b0;
      end else begin
        phase_d      = phase_n;
        pos_d        = pos_n;
        root_alive_d = root_alive_n;
        any_alive_d  = any_alive_n;
        first_comp_d = first_comp_n;
        rest_seen_d  = rest_seen_n;
        match_d      = match_n;
      end
    end
  end

  // result register: loads on the last character, drains when not stalled
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    prot_d      = prot_q;
    root_d      = root_q;
    if (in_xfer && last_char_i) begin
      out_valid_d = 1'b1;
      if (phase_n == PH_SEEK_COLON) begin
        // no device prefix at all
        prot_d = 1'b0;
        root_d = 1'b0;
      end else if (!rest_seen_n) begin
        // nothing after the root
        prot_d = 1'b1;
        root_d = 1'b1;
      end else begin
        prot_d = match_n || comp_hit_n;
        root_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_SEEK_COLON;
      pos_q        <= '0;
      root_alive_q <= '1;
      any_alive_q  <= '1;
      first_comp_q <= 1'b1;
      rest_seen_q  <= 1'b0;
      match_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      pos_q        <= pos_d;
      root_alive_q <= root_alive_d;
      any_alive_q  <= any_alive_d;
      first_comp_q <= first_comp_d;
      rest_seen_q  <= rest_seen_d;
      match_q      <= match_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    prot_q <= prot_d;
    root_q <= root_d;
  end

  assign out_valid_o      = out_valid_q;
  assign is_protected_o   = prot_q;
  assign is_device_root_o = root_q;

endmodule
